/* design/assert_macros.svh */
// Assertion macros for the command line splitter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property checked at every rising clock edge outside reset.
`define CLS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define CLS_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);

`endif

/* design/cls_pkg.sv */
// Types, constants and helpers for the command line splitter.
package cls_pkg;

  localparam int unsigned ArgCountW   = 12;
  localparam int unsigned ArgCountMax = 4095;
  // Saturation point: at most what the count field holds, at least one.
  localparam int unsigned ArgCapRaw   = (ArgCountMax > 4095) ? 4095 : ArgCountMax;
  localparam int unsigned ArgCapInt   = (ArgCapRaw < 1) ? 1 : ArgCapRaw;
  localparam logic [ArgCountW-1:0] ArgCap = ArgCountW'(ArgCapInt);
  localparam logic [ArgCountW-1:0] ArgInit = ArgCountW'(1);

  localparam logic [7:0] CharSingleQ = 8'h27;
  localparam logic [7:0] CharDoubleQ = 8'h22;
  localparam logic [7:0] CharBackslash = 8'h5C;
  localparam logic [7:0] CharNul = 8'h00;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab = 8'h09;
  localparam logic [7:0] CharCr = 8'h0D;

  typedef enum logic [2:0] {
    KIND_CHAR       = 3'd0,
    KIND_BOUNDARY   = 3'd1,
    KIND_DONE       = 3'd2,
    KIND_BAD_ESCAPE = 3'd3,
    KIND_OPEN_QUOTE = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    QM_NONE   = 2'd0,
    QM_SINGLE = 2'd1,
    QM_DOUBLE = 2'd2
  } quote_e;

  typedef struct packed {
    kind_e                kind;
    logic [7:0]           out_char;
    logic [ArgCountW-1:0] arg_count;
  } res_t;

  typedef struct packed {
    quote_e               quote_mode;
    logic                 escape_pending;
    logic                 in_space_run;
    logic [ArgCountW-1:0] args_seen;
  } state_t;

  // C whitespace: tab, newline, vertical tab, form feed, return, space.
  function automatic logic is_ws(logic [7:0] c);
    return (c == CharSpace) || ((c >= CharTab) && (c <= CharCr));
  endfunction

endpackage

/* design/cls_if.sv */
// Valid/ready channel interfaces for command line bytes and result words.
interface cls_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_line;

  modport source (output valid, output ch, output end_of_line, input ready);
  modport sink   (input valid, input ch, input end_of_line, output ready);
endinterface

interface cls_out_if;
  logic                            valid;
  logic                            ready;
  logic [2:0]                      kind;
  logic [7:0]                      out_char;
  logic [cls_pkg::ArgCountW-1:0]   arg_count;

  modport source (output valid, output kind, output out_char, output arg_count,
                  input ready);
  modport sink   (input valid, input kind, input out_char, input arg_count,
                  output ready);
endinterface

/* design/cls_step.sv */
// Splitter state registers and the per-byte update and result decode.
module cls_step (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             advance_i,
  input  logic [7:0]       ch_i,
  input  logic             eol_i,
  output logic             res_valid_o,
  output cls_pkg::res_t    res_o,
  output cls_pkg::state_t  state_o
);

  cls_pkg::state_t state_q, state_d;
  logic            ws;

  assign ws = cls_pkg::is_ws(ch_i);

  // Decode one word against the current state
  always_comb begin
    state_d     = state_q;
    res_valid_o = 1'b0;
    res_o       = '{kind: cls_pkg::KIND_CHAR, out_char: '0, arg_count: '0};
    priority if (eol_i) begin
      res_valid_o = 1'b1;
      priority if (state_q.escape_pending) begin
        res_o.kind = cls_pkg::KIND_BAD_ESCAPE;
      end else if (state_q.quote_mode != cls_pkg::QM_NONE) begin
        res_o.kind = cls_pkg::KIND_OPEN_QUOTE;
      end else begin
        res_o.kind      = cls_pkg::KIND_DONE;
        res_o.arg_count = state_q.args_seen;
      end
      state_d = '{quote_mode: cls_pkg::QM_NONE, escape_pending: 1'b0,
                  in_space_run: 1'b0, args_seen: cls_pkg::ArgInit};
    end else if (ch_i == cls_pkg::CharNul) begin
      // drop NUL bytes
    end else if (state_q.escape_pending) begin
      state_d.escape_pending = 1'b0;
      state_d.in_space_run   = 1'b0;
      res_valid_o            = 1'b1;
      res_o.out_char         = ch_i;
    end else if (state_q.in_space_run && ws) begin
      // skip the rest of a whitespace run
    end else begin
      state_d.in_space_run = 1'b0;
      priority if (state_q.quote_mode == cls_pkg::QM_NONE && ws) begin
        if (state_q.args_seen < cls_pkg::ArgCap) begin
          state_d.args_seen = state_q.args_seen + cls_pkg::ArgCountW'(1);
        end
        state_d.in_space_run = 1'b1;
        res_valid_o          = 1'b1;
        res_o.kind           = cls_pkg::KIND_BOUNDARY;
      end else if (state_q.quote_mode == cls_pkg::QM_NONE &&
                   (ch_i == cls_pkg::CharSingleQ || ch_i == cls_pkg::CharDoubleQ)) begin
        state_d.quote_mode = (ch_i == cls_pkg::CharSingleQ) ? cls_pkg::QM_SINGLE
                                                             : cls_pkg::QM_DOUBLE;
      end else if ((state_q.quote_mode == cls_pkg::QM_SINGLE &&
                    ch_i == cls_pkg::CharSingleQ) ||
                   (state_q.quote_mode == cls_pkg::QM_DOUBLE &&
                    ch_i == cls_pkg::CharDoubleQ)) begin
        state_d.quote_mode = cls_pkg::QM_NONE;
      end else if (ch_i == cls_pkg::CharBackslash &&
                   state_q.quote_mode != cls_pkg::QM_SINGLE) begin
        state_d.escape_pending = 1'b1;
      end else begin
        res_valid_o    = 1'b1;
        res_o.out_char = ch_i;
      end
    end
  end

  // Advance the state only when a word moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{quote_mode: cls_pkg::QM_NONE, escape_pending: 1'b0,
                   in_space_run: 1'b0, args_seen: cls_pkg::ArgInit};
    end else if (advance_i) begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;

endmodule

/* design/cls_out_reg.sv */
// Result register holding one word for the downstream side.
module cls_out_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  cls_pkg::res_t res_i,
  input  logic          ready_i,
  output logic          valid_o,
  output cls_pkg::res_t res_o
);

  logic          valid_q, valid_d;
  cls_pkg::res_t res_q;

  // Fill on load, empty when taken, otherwise hold
  always_comb begin
    priority if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

/* design/command_line_splitter_core.sv */
// Top level of the command line splitter: input register, decode, result register.
//
// Usage: bytes of a command line enter on in_i (ch), one per word; a word with
// end_of_line set closes the line and carries no byte. NUL bytes are dropped.
// Each input word yields zero or one word on out_o: an argument byte (kind
// char), an argument boundary, or at end of line the argument count (done) or
// an error (dangling backslash, unclosed quote). After an end-of-line word the
// parser is back in its reset state and the next line may follow at once.
// A result reaches out_o through the input register and then the result register;
// a stall on out_o can hold a word in the input register between the two.
// Throughput: one word per cycle while out_o is taken; the decode of a byte
// against the quote, escape and whitespace-run state is combinational logic.
// Reset (rst_ni low, asynchronous) empties both registers and clears the
// state: no quotes, no escape, count one.
// When out_o stalls, the result register holds its word and the input
// register holds the next byte; in_i.ready falls once both are full.
`include "assert_macros.svh"

module command_line_splitter_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  cls_in_if.sink    in_i,
  cls_out_if.source out_o
);

  logic            in_valid_q, in_valid_d;
  logic [7:0]      ch_q;
  logic            eol_q;
  logic            advance;
  logic            accept;
  logic            res_valid;
  cls_pkg::res_t   res;
  cls_pkg::res_t   out_res;
  logic            out_valid;
  cls_pkg::state_t state;

  // Move a word into the decode when the result register can take its result
  assign advance    = in_valid_q && (!out_valid || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    priority if (accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end else begin
      in_valid_d = in_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  // Capture the input payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ch_q  <= in_i.ch;
      eol_q <= in_i.end_of_line;
    end
  end

  cls_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .ch_i        (ch_q),
    .eol_i       (eol_q),
    .res_valid_o (res_valid),
    .res_o       (res),
    .state_o     (state)
  );

  cls_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (advance && res_valid),
    .res_i   (res),
    .ready_i (out_o.ready),
    .valid_o (out_valid),
    .res_o   (out_res)
  );

  assign out_o.valid     = out_valid;
  assign out_o.kind      = out_res.kind;
  assign out_o.out_char  = out_res.out_char;
  assign out_o.arg_count = out_res.arg_count;

  // End of line must leave the parser in its reset state
  `CLS_ASSERT(a_eol_clears, clk_i, rst_ni,
              advance && eol_q |=> state.quote_mode == cls_pkg::QM_NONE &&
              !state.escape_pending && !state.in_space_run &&
              state.args_seen == cls_pkg::ArgInit,
              "state not cleared after end of line")
  // Argument count stays within one and the cap
  `CLS_NEVER(a_count_range, clk_i, rst_ni,
             state.args_seen == '0 || state.args_seen > cls_pkg::ArgCap,
             "argument count out of range")
  // Only a byte result carries a byte, only done carries a count
  `CLS_NEVER(a_payload_zero, clk_i, rst_ni,
             out_valid && ((out_res.kind != cls_pkg::KIND_CHAR && out_res.out_char != '0) ||
             (out_res.kind != cls_pkg::KIND_DONE && out_res.arg_count != '0)),
             "stray payload in result word")
  // An empty result register never blocks the input
  `CLS_ASSERT(a_ready_when_empty, clk_i, rst_ni, !out_valid |-> in_i.ready,
              "input stalled with empty result register")

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the command line splitter: directed and random lines.
module testbench;
  import cls_pkg::*;

  localparam int IdleLimit  = 1000;  // cycles with no word moving on either side
  localparam int DrainTail  = 4;     // two-stage latency plus margin
  localparam int RandWords  = 1400;

  logic clk_i;
  logic rst_ni;

  cls_in_if  in_bus ();
  cls_out_if out_bus ();

  command_line_splitter_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // Predicted parser state
  quote_e         quote_now;
  logic           escape_now;
  logic           blank_run;
  logic [11:0]    args_open;

  res_t           pending_results[$];
  logic [7:0]     line_bytes[$];
  int             errors;
  int             words_sent;
  int             idle_cycles;
  bit             src_idle;
  bit             sink_stall;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit is_blank(logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic void clear_parser();
    quote_now  = QM_NONE;
    escape_now = 1'b0;
    blank_run  = 1'b0;
    args_open  = 12'd1;
  endfunction

  // Queue one expected result word
  function automatic void expect_result(res_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  // Append one byte to the line being built
  function automatic void add_byte(logic [7:0] b);
    line_bytes.insert(line_bytes.size(), b);
  endfunction

  // Work out the result of one accepted input word and queue it
  function automatic void split_word(logic [7:0] c, logic eol);
    res_t r;
    r.kind      = KIND_CHAR;
    r.out_char  = 8'h00;
    r.arg_count = '0;
    if (eol) begin
      if (escape_now) begin
        r.kind = KIND_BAD_ESCAPE;
      end else if (quote_now != QM_NONE) begin
        r.kind = KIND_OPEN_QUOTE;
      end else begin
        r.kind      = KIND_DONE;
        r.arg_count = args_open;
      end
      expect_result(r);
      clear_parser();
      return;
    end
    // drop NUL bytes
    if (c == CharNul) return;
    if (escape_now) begin
      escape_now = 1'b0;
      blank_run  = 1'b0;
      r.out_char = c;
      expect_result(r);
      return;
    end
    if (blank_run && is_blank(c)) return;
    blank_run = 1'b0;
    if (quote_now == QM_NONE && is_blank(c)) begin
      if (args_open < ArgCap) args_open = args_open + 12'd1;
      blank_run = 1'b1;
      r.kind    = KIND_BOUNDARY;
      expect_result(r);
      return;
    end
    if (quote_now == QM_NONE && (c == CharSingleQ || c == CharDoubleQ)) begin
      quote_now = (c == CharSingleQ) ? QM_SINGLE : QM_DOUBLE;
      return;
    end
    if ((quote_now == QM_SINGLE && c == CharSingleQ) ||
        (quote_now == QM_DOUBLE && c == CharDoubleQ)) begin
      quote_now = QM_NONE;
      return;
    end
    if (c == CharBackslash && quote_now != QM_SINGLE) begin
      escape_now = 1'b1;
      return;
    end
    r.out_char = c;
    expect_result(r);
  endfunction

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 1;
    if (r < 90) return $urandom_range(2, 4);
    return $urandom_range(10, 30);
  endfunction

  task automatic note_mismatch(string what, int want, int got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    errors++;
  endtask

  // Predict, check and watch for a hang
  always @(posedge clk_i) begin : check_proc
    res_t want;
    if (rst_ni) begin
      if (in_bus.valid && in_bus.ready) split_word(in_bus.ch, in_bus.end_of_line);
      if (out_bus.valid && out_bus.ready) begin
        if (pending_results.size() == 0) begin
          note_mismatch("unexpected result, kind", -1, out_bus.kind);
        end else begin
          want = pending_results.pop_front();
          if (out_bus.kind !== want.kind)
            note_mismatch("kind", want.kind, out_bus.kind);
          if (out_bus.out_char !== want.out_char)
            note_mismatch("out_char", want.out_char, out_bus.out_char);
          if (out_bus.arg_count !== want.arg_count)
            note_mismatch("arg_count", want.arg_count, out_bus.arg_count);
        end
      end
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: no word moved for %0d cycles", $time, IdleLimit);
        $display("command_line_splitter_core test failed");
        $finish;
      end
    end
  end

  // Result sink with random stalls
  initial begin : sink_proc
    int stall;
    stall = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall == 0 && sink_stall && $urandom_range(0, 4) == 0) stall = gap_length();
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        stall--;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Offer one word and hold it until taken; valid stays high afterwards
  task automatic send_word(input logic [7:0] c, input logic eol);
    int gap;
    gap = (src_idle && $urandom_range(0, 3) == 0) ? gap_length() : 0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid       <= 1'b1;
    in_bus.ch          <= c;
    in_bus.end_of_line <= eol;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
  endtask

  task automatic end_line();
    send_word(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Hold the sender until every expected result has come
  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainTail) @(posedge clk_i);
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255));
    while (is_blank(b) || b == CharSingleQ || b == CharDoubleQ || b == CharBackslash);
    return b;
  endfunction

  function automatic logic [7:0] blank_byte();
    int r;
    r = $urandom_range(9, 14);
    return (r == 14) ? CharSpace : 8'(r);
  endfunction

  function automatic logic [7:0] byte_other_than(logic [7:0] x, logic [7:0] y);
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255));
    while (b == x || b == y);
    return b;
  endfunction

  // Append one random fragment of a well-formed line
  function automatic void add_piece();
    int n;
    case ($urandom_range(0, 6))
      0, 1: begin
        n = $urandom_range(1, 6);
        repeat (n) add_byte(plain_byte());
      end
      2: begin
        n = $urandom_range(1, 3);
        repeat (n) add_byte(blank_byte());
      end
      3: begin
        add_byte(CharSingleQ);
        n = $urandom_range(0, 4);
        repeat (n) add_byte(byte_other_than(CharSingleQ, CharSingleQ));
        add_byte(CharSingleQ);
      end
      4: begin
        add_byte(CharDoubleQ);
        n = $urandom_range(0, 4);
        repeat (n) begin
          if ($urandom_range(0, 3) == 0) begin
            add_byte(CharBackslash);
            add_byte(8'($urandom_range(1, 255)));
          end else begin
            add_byte(byte_other_than(CharDoubleQ, CharBackslash));
          end
        end
        add_byte(CharDoubleQ);
      end
      5: begin
        add_byte(CharBackslash);
        add_byte(8'($urandom_range(1, 255)));
      end
      default: add_byte(CharNul);
    endcase
  endfunction

  // Edge bytes, quoting, escapes and every end-of-line outcome
  task automatic test_directed_cases();
    src_idle   = 1'b0;
    sink_stall = 1'b0;
    // empty line
    end_line();
    // leading blank run, extreme bytes, NUL, trailing blank
    send_word(CharSpace, 1'b0);
    send_word(CharTab, 1'b0);
    send_word(8'h01, 1'b0);
    send_word(CharNul, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(CharCr, 1'b0);
    end_line();
    src_idle   = 1'b1;
    sink_stall = 1'b1;
    // escaped quote in double quotes, backslash in single quotes, escaped space
    send_text("\"\\\"\" '\\' \\ ");
    end_line();
    // backslash at end inside double quotes
    send_text("\"\\");
    end_line();
    // unclosed single quote
    send_text("'a");
    end_line();
    // dangling backslash
    send_text("\\");
    end_line();
    wait_drained();
  endtask

  // Mostly well-formed lines, some broken ones and some noise
  task automatic test_random_lines();
    int shape;
    int n;
    int line_no;
    int start_count;
    line_no     = 0;
    start_count = words_sent;
    while (words_sent < start_count + RandWords) begin
      src_idle   = ($urandom_range(0, 4) != 0);
      sink_stall = ($urandom_range(0, 4) != 0);
      line_bytes.delete();
      shape = $urandom_range(0, 99);
      if (shape < 8) begin
        n = $urandom_range(1, 12);
        repeat (n) add_byte(8'($urandom_range(0, 255)));
      end else begin
        n = $urandom_range(0, 8);
        repeat (n) add_piece();
        if (shape < 14) begin
          add_byte(($urandom_range(0, 1) == 0) ? CharSingleQ : CharDoubleQ);
          n = $urandom_range(0, 3);
          repeat (n) add_byte(plain_byte());
        end else if (shape < 20) begin
          add_byte(CharBackslash);
        end
      end
      foreach (line_bytes[i]) send_word(line_bytes[i], 1'b0);
      end_line();
      line_no++;
      if (line_no % 25 == 0) wait_drained();
    end
  endtask

  // Main sequence
  initial begin
    in_bus.valid       = 1'b0;
    in_bus.ch          = 8'h00;
    in_bus.end_of_line = 1'b0;
    rst_ni             = 1'b0;
    errors             = 0;
    words_sent         = 0;
    idle_cycles        = 0;
    src_idle           = 1'b0;
    sink_stall         = 1'b0;
    clear_parser();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_random_lines();
    wait_drained();

    if (errors == 0 && pending_results.size() == 0) begin
      $display("command_line_splitter_core test passed");
    end else begin
      $display("command_line_splitter_core test failed");
    end
    $finish;
  end

endmodule
